FILE: rtl/core/msud_pkg.sv
// Package for the metaspace UTF-8 decoder: result descriptor type and code constants.
// No dependencies; imported by every module of the decoder.
`default_nettype none
package msud_pkg;

   localparam int CpWidth = 21;

   localparam logic [CpWidth-1:0] REPL_CP       = 21'h00FFFD;
   localparam logic [CpWidth-1:0] SPACE_MARK_CP = 21'h002581;
   localparam logic [7:0]         SPACE_BYTE    = 8'h20;

   // one entry per accepted byte that gives results:
   // count results, all REPL_CP but the last, which is last_cp
   typedef struct packed {
      logic [2:0]         count;
      logic [CpWidth-1:0] last_cp;
      logic               text_end;
   } desc_type;

   localparam int DescWidth = $bits(desc_type);

endpackage
`default_nettype wire

FILE: rtl/core/msud_front.sv
// Front end: csr register, UTF-8 sequence state and per-byte result descriptor.
// Depends on msud_pkg.
`default_nettype none
module msud_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_wr_en,
   input  wire                 csr_wr_data,
   input  wire                 in_accept,
   input  wire [7:0]           in_byte,
   input  wire                 text_end,
   output logic                desc_valid,
   output msud_pkg::desc_type  desc
);
   import msud_pkg::*;

   logic                space_en_ff;
   logic [2:0]          exp_ff, exp_in;
   logic [1:0]          taken_ff, taken_in;
   logic [CpWidth-1:0]  pv_ff, pv_in;

   logic                pend, cont, lead;
   logic                sb_emit;
   logic [CpWidth-1:0]  sb_cp, sb_pv, pv_nx;
   logic [2:0]          sb_exp, taken_w;
   logic [1:0]          t_nx;
   logic [2:0]          cnt;
   logic [CpWidth-1:0]  last;

   always_comb begin
      sb_emit = 1'b0;
      sb_cp   = REPL_CP;
      sb_exp  = 3'd0;
      sb_pv   = '0;
      if (!in_byte[7]) begin
         sb_emit = 1'b1;
         sb_cp   = {13'd0, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
         sb_exp = 3'd2;
         sb_pv  = {16'd0, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
         sb_exp = 3'd3;
         sb_pv  = {17'd0, in_byte[3:0]};
      end else if (in_byte[7:3] == 5'b11110) begin
         sb_exp = 3'd4;
         sb_pv  = {18'd0, in_byte[2:0]};
      end else begin
         sb_emit = 1'b1;
      end
   end

   always_comb begin
      pend     = (exp_ff != 3'd0);
      cont     = (in_byte[7:6] == 2'b10);
      lead     = (sb_exp != 3'd0);
      taken_w  = {1'b0, taken_ff};
      pv_nx    = {pv_ff[CpWidth-7:0], in_byte[5:0]};
      t_nx     = taken_ff + 2'd1;
      exp_in   = exp_ff;
      taken_in = taken_ff;
      pv_in    = pv_ff;
      cnt      = 3'd0;
      last     = REPL_CP;
      if (space_en_ff && (in_byte == SPACE_BYTE)) begin
         cnt      = pend ? taken_w + 3'd1 : 3'd1;
         last     = SPACE_MARK_CP;
         exp_in   = 3'd0;
         taken_in = 2'd0;
         pv_in    = '0;
      end else if (pend && cont) begin
         if (({1'b0, t_nx} >= exp_ff) || (t_nx == 2'd0)) begin
            cnt      = 3'd1;
            last     = pv_nx;
            exp_in   = 3'd0;
            taken_in = 2'd0;
            pv_in    = '0;
         end else if (text_end) begin
            cnt      = {1'b0, t_nx};
            exp_in   = 3'd0;
            taken_in = 2'd0;
            pv_in    = '0;
         end else begin
            taken_in = t_nx;
            pv_in    = pv_nx;
         end
      end else begin
         // flush any pending bytes, then treat this byte as a new start
         cnt      = pend ? taken_w : 3'd0;
         exp_in   = 3'd0;
         taken_in = 2'd0;
         pv_in    = '0;
         if (sb_emit) begin
            cnt  = cnt + 3'd1;
            last = sb_cp;
         end else if (lead) begin
            if (text_end) begin
               cnt = cnt + 3'd1;
            end else begin
               exp_in   = sb_exp;
               taken_in = 2'd1;
               pv_in    = sb_pv;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_en_ff <= 1'b1;
         exp_ff      <= 3'd0;
         taken_ff    <= 2'd0;
         pv_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            space_en_ff <= csr_wr_data;
         end
         if (in_accept) begin
            exp_ff   <= exp_in;
            taken_ff <= taken_in;
            pv_ff    <= pv_in;
         end
      end
   end

   assign desc_valid    = in_accept && (cnt != 3'd0);
   assign desc.count    = cnt;
   assign desc.last_cp  = last;
   assign desc.text_end = text_end;

endmodule
`default_nettype wire

FILE: rtl/core/msud_fifo.sv
// Descriptor queue between front and back ends; register-based circular buffer.
// Depends on msud_pkg.
`default_nettype none
module msud_fifo #(
   parameter int DEPTH = 4
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 wr_en,
   input  msud_pkg::desc_type  wr_data,
   input  wire                 rd_en,
   output msud_pkg::desc_type  rd_data,
   output logic                empty,
   output logic                full
);
   import msud_pkg::*;

   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW  = $clog2(DEPTH + 1);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);
   localparam logic [CntW-1:0]  FullCnt  = CntW'(DEPTH);

   desc_type            mem_ff [DEPTH];
   logic [AddrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     cnt_ff;
   logic                do_wr, do_rd;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == FullCnt);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + AddrW'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + AddrW'(1);
         end
         if (do_wr && !do_rd) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end else if (do_rd && !do_wr) begin
            cnt_ff <= cnt_ff - CntW'(1);
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/msud_back.sv
// Back end: expands descriptors into code points in the output register, one per ready cycle.
// Depends on msud_pkg.
`default_nettype none
module msud_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 desc_avail,
   input  msud_pkg::desc_type  desc,
   output logic                desc_pop,
   output logic                out_valid,
   input  wire                 out_ready,
   output logic [20:0]         out_cp,
   output logic                out_run_last,
   output logic                out_text_done
);
   import msud_pkg::*;

   logic                valid_ff;
   logic [CpWidth-1:0]  cp_ff;
   logic                run_last_ff, text_done_ff;
   logic [1:0]          idx_ff, idx_in;
   logic                load, is_last;

   assign load     = desc_avail && (!valid_ff || out_ready);
   assign is_last  = ({1'b0, idx_ff} == (desc.count - 3'd1));
   assign desc_pop = load && is_last;
   assign idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff        <= is_last ? desc.last_cp : REPL_CP;
         run_last_ff  <= is_last;
         text_done_ff <= is_last && desc.text_end;
      end
   end

   assign out_valid     = valid_ff;
   assign out_cp        = cp_ff;
   assign out_run_last  = run_last_ff;
   assign out_text_done = text_done_ff;

endmodule
`default_nettype wire

FILE: rtl/core/metaspace_utf8_decoder_unit.sv
// Top level of the metaspace UTF-8 decoder: front end, descriptor queue, back end.
// Depends on msud_pkg, msud_front, msud_fifo, msud_back.
//
// Takes one text byte per cycle while the descriptor queue has room and gives
// Unicode code points, one per cycle while the sink is ready, from a registered
// output. Each byte yields 0 to 4 code points; a byte with k results occupies
// the output for k transfers, and the QUEUE_DEPTH-entry queue absorbs these
// bursts, so input stalls only when results pile up faster than one per cycle
// or the sink stalls. A byte's first result passes through the descriptor queue
// and then the output register. With csr_wr_data high (the reset value), byte
// 0x20 becomes U+2581. Invalid or truncated sequences give one U+FFFD per byte
// taken; no overlong or surrogate checks are done.
`default_nettype none
module metaspace_utf8_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_wr_en,
   input  wire          csr_wr_data,   // space_marker_enable
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,     // [7:0] in_byte
   input  wire          req_tlast,     // text_end
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [23:0]  rsp_tdata,     // [20:0] code_point, [23:21] zero
   output logic         rsp_tlast,     // run_last
   output logic         rsp_tuser      // text_done
);
   import msud_pkg::*;

   desc_type      fr_desc, q_desc;
   logic          fr_valid, q_empty, q_full, q_pop;
   logic          in_accept;
   logic [20:0]   cp;

   assign req_tready = !q_full;
   assign in_accept  = req_tvalid && req_tready;

   msud_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_accept   (in_accept),
      .in_byte     (req_tdata),
      .text_end    (req_tlast),
      .desc_valid  (fr_valid),
      .desc        (fr_desc)
   );

   msud_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fr_valid),
      .wr_data (fr_desc),
      .rd_en   (q_pop),
      .rd_data (q_desc),
      .empty   (q_empty),
      .full    (q_full)
   );

   msud_back u_back (
      .clock         (clock),
      .reset         (reset),
      .desc_avail    (!q_empty),
      .desc          (q_desc),
      .desc_pop      (q_pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_cp        (cp),
      .out_run_last  (rsp_tlast),
      .out_text_done (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, cp};

endmodule
`default_nettype wire

FILE: rtl/core/msud_checker.sv
// Port-level assertions for metaspace_utf8_decoder_unit, attached by bind.
// Depends on metaspace_utf8_decoder_unit ports only.
`default_nettype none
module msud_checker (
   input wire          clock,
   input wire          reset,
   input wire          rsp_tvalid,
   input wire          rsp_tready,
   input wire [23:0]   rsp_tdata,
   input wire          rsp_tlast,
   input wire          rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("text_done without run_last");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:21] == 3'b000)
      else $error("rsp_tdata pad bits set");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind metaspace_utf8_decoder_unit msud_checker u_msud_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
